>>> hdl/cea_pkg.sv
// Package with the command, status and queue types of the extent allocator.
`default_nettype none
package cea_pkg;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 3;
	localparam int ADDR_BITS = 16;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE = 2'd1,
		CMD_COMPACT = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_SPACE = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ZERO_LEN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST = 2'd1,
		FIT_WORST = 2'd2,
		FIT_SPARE = 2'd3
	} fit_t;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_FIT_MODE = 1'b1;

	// Work item handed from the front part to the back part.
	typedef struct packed {
		cmd_t cmd;
		logic [16:0] length;
		logic [15:0] start_addr;
	} work_t;
endpackage
`default_nettype wire

>>> hdl/cea_front.sv
// Front part: accepts commands, drops unused codes and queues the rest.
`default_nettype none
module cea_front
	import cea_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] cmd,
	input wire logic [16:0] length,
	input wire logic [15:0] start_addr,
	output logic q_valid,
	input wire logic q_ready,
	output work_t q_data
);
	work_t slot_q [2];
	logic [1:0] valid_q;
	logic rd_q;
	logic wr_q;
	logic push;
	logic pop;
	logic keep;

	assign in_ready = !(valid_q[0] && valid_q[1]);
	assign keep = cmd_t'(cmd) != CMD_NONE;
	assign push = in_valid && in_ready && keep;
	assign pop = q_valid && q_ready;
	assign q_valid = valid_q[rd_q];
	assign q_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{cmd_t'(cmd), length, start_addr};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) begin
				valid_q[wr_q] <= 1'b1;
				wr_q <= !wr_q;
			end
			if (pop) begin
				valid_q[rd_q] <= 1'b0;
				rd_q <= !rd_q;
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/cea_back.sv
// Back part: scans, searches, shifts and compacts the extent table, one entry a cycle unless the output stalls.
`default_nettype none
module cea_back
	import cea_pkg::*;
#(
	parameter int MAX_EXTENTS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input work_t q_data,
	input wire logic [16:0] capacity,
	input wire logic [1:0] fit_mode,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [15:0] address,
	output logic [15:0] new_address,
	output logic last
);
	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int AW = ADDR_BITS + 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_SHIFT = 7'b0000100,
		S_FIND = 7'b0001000,
		S_PULL = 7'b0010000,
		S_PACK = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [ADDR_BITS-1:0] first_q [MAX_EXTENTS];
	logic [ADDR_BITS-1:0] final_q [MAX_EXTENTS];
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] pos_q;
	logic [AW-1:0] prev_end_q;
	logic [AW-1:0] best_size_q;
	logic [AW-1:0] best_start_q;
	logic found_q;
	work_t work_q;
	logic [AW-1:0] cap_sat;
	logic [AW:0] gap_end;
	logic [AW:0] gap_size;
	logic fits;
	logic take;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] ext_len;
	logic [IW-1:0] ki;
	logic [IW-1:0] km;
	logic out_busy;
	logic [2:0] r_status;
	logic [15:0] r_addr;
	logic [15:0] r_new;
	logic r_last;
	logic r_fire;

	assign ki = k_q[IW-1:0];
	assign km = IW'(k_q - CW'(1));
	assign cap_sat = (capacity > 17'(AW'(1) << ADDR_BITS) && AW <= 17) ?
		AW'(AW'(1) << ADDR_BITS) : ((AW > 17) ? AW'(capacity) :
		((capacity > 17'(AW'(1) << ADDR_BITS)) ? AW'(AW'(1) << ADDR_BITS) : AW'(capacity)));
	assign gap_end = (k_q == count_q) ? {1'b0, cap_sat} : {2'b0, first_q[ki]};
	assign gap_size = gap_end - {1'b0, prev_end_q};
	assign fits = !gap_size[AW] && (gap_size[AW-1:0] >= AW'(work_q.length));
	always_comb begin
		case (fit_t'(fit_mode))
			FIT_BEST: take = !found_q || gap_size[AW-1:0] < best_size_q;
			FIT_WORST: take = !found_q || gap_size[AW-1:0] > best_size_q;
			default: take = 1'b1;
		endcase
	end
	assign ext_len = AW'(final_q[ki]) - AW'(first_q[ki]) + AW'(1);
	assign out_busy = out_valid && !out_ready;
	assign q_ready = (state_q == S_IDLE) && !out_busy;

	always_ff @(posedge clk) begin
		if (r_fire) begin
			status <= r_status;
			address <= r_addr;
			new_address <= r_new;
			last <= r_last;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_SHIFT: begin
				if (k_q > pos_q) begin
					first_q[ki] <= first_q[km];
					final_q[ki] <= final_q[km];
				end else begin
					first_q[ki] <= best_start_q[ADDR_BITS-1:0];
					final_q[ki] <= ADDR_BITS'(best_start_q + AW'(work_q.length) - AW'(1));
				end
			end
			S_PULL: begin
				if (k_q + CW'(1) < count_q) begin
					first_q[ki] <= first_q[IW'(k_q + CW'(1))];
					final_q[ki] <= final_q[IW'(k_q + CW'(1))];
				end
			end
			S_PACK: begin
				if (!out_busy) begin
					first_q[ki] <= cur_q[ADDR_BITS-1:0];
					final_q[ki] <= ADDR_BITS'(cur_q + ext_len - AW'(1));
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		r_fire = 1'b0;
		r_status = ST_OK;
		r_addr = '0;
		r_new = '0;
		r_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (q_valid && !out_busy) begin
					if (q_data.cmd == CMD_ALLOC && q_data.length == '0) begin
						r_fire = 1'b1;
						r_status = ST_ZERO_LEN;
					end else if (q_data.cmd == CMD_ALLOC && count_q >= CW'(MAX_EXTENTS)) begin
						r_fire = 1'b1;
						r_status = ST_TABLE_FULL;
					end else if (q_data.cmd == CMD_COMPACT && count_q == '0) begin
						r_fire = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (!out_busy && k_q == count_q && !(fits && take) && !found_q) begin
					r_fire = 1'b1;
					r_status = ST_NO_SPACE;
				end
			end
			S_SHIFT: begin
				if (!out_busy && k_q == pos_q) begin
					r_fire = 1'b1;
					r_addr = 16'(best_start_q);
				end
			end
			S_FIND: begin
				if (!out_busy && k_q == count_q) begin
					r_fire = 1'b1;
					r_status = ST_NOT_FOUND;
					r_addr = 16'(work_q.start_addr);
				end
			end
			S_PULL: begin
				if (!out_busy && k_q + CW'(1) >= count_q) begin
					r_fire = 1'b1;
					r_addr = 16'(work_q.start_addr);
				end
			end
			S_PACK: begin
				if (!out_busy) begin
					r_fire = 1'b1;
					r_addr = 16'(first_q[ki]);
					r_new = 16'(cur_q);
					r_last = (k_q + CW'(1) == count_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q <= '0;
			pos_q <= '0;
			prev_end_q <= '0;
			best_size_q <= '0;
			best_start_q <= '0;
			found_q <= 1'b0;
			cur_q <= '0;
			out_valid <= 1'b0;
			work_q <= '0;
		end else begin
			out_valid <= r_fire || (out_valid && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (q_valid && !out_busy) begin
						work_q <= q_data;
						k_q <= '0;
						prev_end_q <= '0;
						found_q <= 1'b0;
						cur_q <= '0;
						if (!r_fire) begin
							case (q_data.cmd)
								CMD_ALLOC: state_q <= S_SCAN;
								CMD_FREE: state_q <= S_FIND;
								default: state_q <= S_PACK;
							endcase
						end
					end
				end
				S_SCAN: begin
					if (!out_busy) begin
						if (fits && take) begin
							found_q <= 1'b1;
							best_size_q <= gap_size[AW-1:0];
							best_start_q <= prev_end_q;
							pos_q <= k_q;
						end
						if (k_q == count_q || (fits && (fit_mode == FIT_FIRST ||
							fit_mode == FIT_SPARE))) begin
							if (found_q || (fits && take)) begin
								state_q <= S_SHIFT;
								k_q <= count_q;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							prev_end_q <= AW'(final_q[ki]) + AW'(1);
							k_q <= k_q + CW'(1);
						end
					end
				end
				S_SHIFT: begin
					if (k_q > pos_q) begin
						k_q <= k_q - CW'(1);
					end else if (!out_busy) begin
						count_q <= count_q + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_FIND: begin
					if (!out_busy) begin
						if (k_q == count_q) begin
							state_q <= S_IDLE;
						end else if (first_q[ki] == ADDR_BITS'(work_q.start_addr) &&
							(ADDR_BITS >= 16 || 16'(first_q[ki]) == work_q.start_addr)) begin
							state_q <= S_PULL;
						end else begin
							k_q <= k_q + CW'(1);
						end
					end
				end
				S_PULL: begin
					if (k_q + CW'(1) < count_q) begin
						k_q <= k_q + CW'(1);
					end else if (!out_busy) begin
						count_q <= count_q - CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_PACK: begin
					if (!out_busy) begin
						cur_q <= cur_q + ext_len;
						if (k_q + CW'(1) == count_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/contiguous_extent_allocator.sv
// The back part walks the extent table one entry a cycle, unless the output stalls, for the gap
// scan, the free search and the compaction, and once more for the insert or remove shift.
// Throughput: one command at a time in the back part, a two-entry queue in front.
// Reset: the extent count clears, capacity resets to 65536 and fit mode to first fit.
// Table contents are not cleared; only entries below the count are ever read.
`default_nettype none
module contiguous_extent_allocator
	import cea_pkg::*;
#(
	parameter int MAX_EXTENTS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] cmd,
	input wire logic [16:0] length,
	input wire logic [15:0] start_addr,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [15:0] address,
	output logic [15:0] new_address,
	output logic last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [16:0] cfg_data
);
	logic [16:0] capacity_q;
	logic [1:0] fit_mode_q;
	logic q_valid;
	logic q_ready;
	work_t q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 17'h10000;
			fit_mode_q <= FIT_FIRST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAPACITY: capacity_q <= cfg_data;
				CFG_FIT_MODE: fit_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	cea_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .length(length), .start_addr(start_addr),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	cea_back #(.MAX_EXTENTS(MAX_EXTENTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.capacity(capacity_q), .fit_mode(fit_mode_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .address(address), .new_address(new_address), .last(last)
	);
endmodule
`default_nettype wire
